FILE: src/tkd_pkg.sv
// Shared types, codes and constants for the terminal key decoder.
`default_nettype none
package tkd_pkg;

  typedef enum logic [3:0] {
    CMD_INSERT     = 4'd0,
    CMD_HOME       = 4'd1,
    CMD_END        = 4'd2,
    CMD_LEFT       = 4'd3,
    CMD_RIGHT      = 4'd4,
    CMD_OLDER      = 4'd5,
    CMD_NEWER      = 4'd6,
    CMD_BACKSPACE  = 4'd7,
    CMD_DELETE     = 4'd8,
    CMD_CTRL_D     = 4'd9,
    CMD_KILL_END   = 4'd10,
    CMD_KILL_START = 4'd11,
    CMD_KILL_WORD  = 4'd12,
    CMD_COMPLETE   = 4'd13,
    CMD_ACCEPT     = 4'd14
  } cmd_t;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_SEEN  = 2'd1,
    ESC_CSI   = 2'd2,
    ESC_SS3   = 2'd3
  } esc_t;

  localparam logic       REQ_BYTE   = 1'b0;
  localparam logic       REQ_TICK   = 1'b1;
  localparam logic [7:0] KEY_ESCAPE = 8'h1B;
  localparam logic [7:0] KEY_TAB    = 8'h09;
  localparam logic [7:0] KEY_DEL    = 8'h7F;
  localparam logic [13:0] CSI_FREEZE = 14'd1000;

  typedef struct packed {
    esc_t        esc;
    logic [13:0] csi_num;
    logic        csi_sep;
    logic [23:0] pend;
    logic [2:0]  have;
    logic [2:0]  need;
    logic        last_tab;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    cmd_t        command;
    logic [31:0] char_bytes;
    logic [2:0]  char_len;
    logic        tab_repeat;
  } dec_result_t;

endpackage
`default_nettype wire

FILE: src/tkd_decode.sv
// Combinational decode of one word against the current decoder state.
`default_nettype none
module tkd_decode (
  input  wire logic                 req_type,
  input  wire logic [7:0]           key_byte,
  input  wire tkd_pkg::dec_state_t  cur,
  output tkd_pkg::dec_state_t       nxt,
  output tkd_pkg::dec_result_t      res
);

  function automatic tkd_pkg::dec_result_t cmd_res(input tkd_pkg::cmd_t c);
    tkd_pkg::dec_result_t r;
    r.valid      = 1'b1;
    r.command    = c;
    r.char_bytes = 32'd0;
    r.char_len   = 3'd0;
    r.tab_repeat = 1'b0;
    return r;
  endfunction

  function automatic tkd_pkg::dec_result_t no_res();
    tkd_pkg::dec_result_t r;
    r = cmd_res(tkd_pkg::CMD_INSERT);
    r.valid = 1'b0;
    return r;
  endfunction

  // final byte of CSI / SS3 sequence
  function automatic tkd_pkg::dec_result_t map_final(input logic [7:0] fin,
                                                     input logic [13:0] num);
    tkd_pkg::dec_result_t r;
    r = no_res();
    unique case (fin)
      8'h41: r = cmd_res(tkd_pkg::CMD_OLDER);
      8'h42: r = cmd_res(tkd_pkg::CMD_NEWER);
      8'h43: r = cmd_res(tkd_pkg::CMD_RIGHT);
      8'h44: r = cmd_res(tkd_pkg::CMD_LEFT);
      8'h48: r = cmd_res(tkd_pkg::CMD_HOME);
      8'h46: r = cmd_res(tkd_pkg::CMD_END);
      8'h7E: begin
        if (num == 14'd1 || num == 14'd7) r = cmd_res(tkd_pkg::CMD_HOME);
        else if (num == 14'd4 || num == 14'd8) r = cmd_res(tkd_pkg::CMD_END);
        else if (num == 14'd3) r = cmd_res(tkd_pkg::CMD_DELETE);
      end
      default: r = no_res();
    endcase
    return r;
  endfunction

  function automatic tkd_pkg::dec_result_t control_cmd(input logic [7:0] b);
    tkd_pkg::dec_result_t r;
    r = no_res();
    unique case (b) inside
      8'h0D, 8'h0A: r = cmd_res(tkd_pkg::CMD_ACCEPT);
      8'h04:        r = cmd_res(tkd_pkg::CMD_CTRL_D);
      8'h01:        r = cmd_res(tkd_pkg::CMD_HOME);
      8'h05:        r = cmd_res(tkd_pkg::CMD_END);
      8'h02:        r = cmd_res(tkd_pkg::CMD_LEFT);
      8'h06:        r = cmd_res(tkd_pkg::CMD_RIGHT);
      8'h10:        r = cmd_res(tkd_pkg::CMD_OLDER);
      8'h0E:        r = cmd_res(tkd_pkg::CMD_NEWER);
      8'h08, 8'h7F: r = cmd_res(tkd_pkg::CMD_BACKSPACE);
      8'h0B:        r = cmd_res(tkd_pkg::CMD_KILL_END);
      8'h15:        r = cmd_res(tkd_pkg::CMD_KILL_START);
      8'h17:        r = cmd_res(tkd_pkg::CMD_KILL_WORD);
      default:      r = no_res();
    endcase
    return r;
  endfunction

  logic [1:0]  slot;
  logic [31:0] full;
  logic [2:0]  have_inc;
  logic [3:0]  digit;
  logic        is_cont;

  always_comb begin
    slot     = (cur.have > 3'd3) ? 2'd3 : cur.have[1:0];
    full     = {8'd0, cur.pend} | ({24'd0, key_byte} << {slot, 3'b000});
    have_inc = {1'b0, slot} + 3'd1;
    digit    = key_byte[3:0];
    is_cont  = (key_byte[7:6] == 2'b10);
  end

  always_comb begin
    nxt = cur;
    res = no_res();
    if (req_type == tkd_pkg::REQ_TICK) begin
      if (cur.esc == tkd_pkg::ESC_SEEN) nxt.esc = tkd_pkg::ESC_NONE;
    end else begin
      nxt.last_tab = 1'b0;
      if (cur.esc != tkd_pkg::ESC_NONE) begin
        unique case (cur.esc)
          tkd_pkg::ESC_SEEN: begin
            if (key_byte == 8'h5B) begin
              nxt.esc     = tkd_pkg::ESC_CSI;
              nxt.csi_num = 14'd0;
              nxt.csi_sep = 1'b0;
            end else if (key_byte == 8'h4F) begin
              nxt.esc = tkd_pkg::ESC_SS3;
            end else begin
              nxt.esc = tkd_pkg::ESC_NONE;
            end
          end
          tkd_pkg::ESC_SS3: begin
            nxt.esc = tkd_pkg::ESC_NONE;
            res     = map_final(key_byte, 14'd0);
          end
          tkd_pkg::ESC_CSI: begin
            if (key_byte >= 8'h30 && key_byte <= 8'h39) begin
              // number stops growing at four digits or after ';'
              if (!cur.csi_sep && cur.csi_num < tkd_pkg::CSI_FREEZE)
                nxt.csi_num = 14'(cur.csi_num * 14'd10 + {10'd0, digit});
            end else if (key_byte == 8'h3B) begin
              nxt.csi_sep = 1'b1;
            end else if (!(key_byte >= 8'h20 && key_byte <= 8'h3F)) begin
              nxt.esc = tkd_pkg::ESC_NONE;
              if (key_byte >= 8'h40 && key_byte <= 8'h7E)
                res = map_final(key_byte, cur.csi_num);
            end
          end
          default: nxt.esc = tkd_pkg::ESC_NONE;
        endcase
      end else if (cur.need != 3'd0 && is_cont) begin
        if (have_inc >= cur.need) begin
          res            = cmd_res(tkd_pkg::CMD_INSERT);
          res.char_bytes = full;
          res.char_len   = (cur.need > 3'd4) ? 3'd4 : cur.need;
          nxt.pend       = 24'd0;
          nxt.have       = 3'd0;
          nxt.need       = 3'd0;
        end else begin
          nxt.pend = full[23:0];
          nxt.have = have_inc;
        end
      end else begin
        // broken character is dropped, then the word decodes as fresh
        nxt.pend = 24'd0;
        nxt.have = 3'd0;
        nxt.need = 3'd0;
        if (key_byte == tkd_pkg::KEY_ESCAPE) begin
          nxt.esc = tkd_pkg::ESC_SEEN;
        end else if (key_byte == tkd_pkg::KEY_TAB) begin
          nxt.last_tab   = 1'b1;
          res            = cmd_res(tkd_pkg::CMD_COMPLETE);
          res.tab_repeat = cur.last_tab;
        end else if (key_byte < 8'h20 || key_byte == tkd_pkg::KEY_DEL) begin
          res = control_cmd(key_byte);
        end else if (key_byte < 8'h80) begin
          res            = cmd_res(tkd_pkg::CMD_INSERT);
          res.char_bytes = {24'd0, key_byte};
          res.char_len   = 3'd1;
        end else begin
          if (key_byte >= 8'hF0 && key_byte <= 8'hF4)      nxt.need = 3'd4;
          else if (key_byte >= 8'hE0 && key_byte < 8'hF0)  nxt.need = 3'd3;
          else if (key_byte >= 8'hC2 && key_byte < 8'hE0)  nxt.need = 3'd2;
          if (key_byte >= 8'hC2 && key_byte <= 8'hF4) begin
            nxt.pend = {16'd0, key_byte};
            nxt.have = 3'd1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/tkd_out_reg.sv
// Result register with valid/ready handshake towards the consumer.
`default_nettype none
module tkd_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire tkd_pkg::dec_result_t  res,
  output logic                       free,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [3:0]                 command,
  output logic [31:0]                char_bytes,
  output logic [2:0]                 char_len,
  output logic                       tab_repeat
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      command    <= res.command;
      char_bytes <= res.char_bytes;
      char_len   <= res.char_len;
      tab_repeat <= res.tab_repeat;
    end
  end

endmodule
`default_nettype wire

FILE: src/terminal_key_decoder_core.sv
// Top level of the terminal key decoder: input register, state, decode, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | in        | in_valid / in_ready  | req_type, key_byte
//  out     | out       | out_valid / out_ready| command, char_bytes, char_len, tab_repeat
//
// One word a cycle sustained while the output takes results; an accepted word is held in
// the input register, decoded in one pass against the state registers, and its result
// is then loaded into the result register, from which the consumer takes it.
// Synchronous reset clears the state, the input stage and the result valid.
// A stalled result holds the input stage only when that word has a result to post;
// words with no result drain past a stalled output.
`default_nettype none
module terminal_key_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [7:0]  key_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       command,
  output logic [31:0]      char_bytes,
  output logic [2:0]       char_len,
  output logic             tab_repeat
);

  logic                 s1_valid;
  logic                 s1_req;
  logic [7:0]           s1_byte;
  tkd_pkg::dec_state_t  state;
  tkd_pkg::dec_state_t  state_next;
  tkd_pkg::dec_result_t res;
  logic                 out_free;
  logic                 s1_go;

  assign s1_go    = s1_valid && (!res.valid || out_free);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req  <= req_type;
      s1_byte <= key_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_go) begin
      state <= state_next;
    end
  end

  tkd_decode u_decode (
    .req_type (s1_req),
    .key_byte (s1_byte),
    .cur      (state),
    .nxt      (state_next),
    .res      (res)
  );

  tkd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_go && res.valid),
    .res        (res),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .command    (command),
    .char_bytes (char_bytes),
    .char_len   (char_len),
    .tab_repeat (tab_repeat)
  );

endmodule
`default_nettype wire

FILE: src/tkd_checker.sv
// Port-level checks for the terminal key decoder, bound to the top level.
`default_nettype none
module tkd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  command,
  input wire logic [31:0] char_bytes,
  input wire logic [2:0]  char_len,
  input wire logic        tab_repeat
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command) && $stable(char_bytes)
      && $stable(char_len) && $stable(tab_repeat))
    else $error("result word changed while stalled");

  a_no_chars: assert property (@(posedge clk) disable iff (rst)
    out_valid && command != tkd_pkg::CMD_INSERT |-> char_len == 3'd0 && char_bytes == 32'd0)
    else $error("character bytes on a non-insert command");

  a_insert_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == tkd_pkg::CMD_INSERT |-> char_len >= 3'd1 && char_len <= 3'd4)
    else $error("insert with bad length");

  a_tab_rep: assert property (@(posedge clk) disable iff (rst)
    out_valid && tab_repeat |-> command == tkd_pkg::CMD_COMPLETE)
    else $error("tab repeat on a command other than complete");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind terminal_key_decoder_core tkd_checker u_tkd_checker (.*);
`default_nettype wire

FILE: bench/tb_terminal_key_decoder_core.sv
// Self-checking testbench for the terminal key decoder core: directed keys, then random traffic.
`timescale 1ns / 1ps
module tb_terminal_key_decoder_core;
  import tkd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_WORDS = 1850;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] bytes;
    logic [2:0]  len;
    logic        rep;
  } key_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_BYTE;
  logic [7:0]  key_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  command;
  logic [31:0] char_bytes;
  logic [2:0]  char_len;
  logic        tab_repeat;

  // decoder state as predicted
  esc_t        esc_st = ESC_NONE;
  logic [13:0] csi_val = '0;
  logic        csi_frozen = 1'b0;
  logic [23:0] utf_pend = '0;
  logic [2:0]  utf_have = '0;
  logic [2:0]  utf_need = '0;
  logic        last_tab = 1'b0;

  key_word_t awaited_keys[$];
  bit        idle_on = 1'b1;
  bit        seen_cmd [16];
  int        mismatches = 0;
  int        words_sent = 0;
  int        ticks_sent = 0;
  int        results_checked = 0;
  int        cycles = 0;
  int        rd_hold = 0;

  terminal_key_decoder_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .key_byte   (key_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .command    (command),
    .char_bytes (char_bytes),
    .char_len   (char_len),
    .tab_repeat (tab_repeat)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic bit final_key(input logic [7:0] f, input logic [13:0] num,
                                   output cmd_t c);
    c = CMD_INSERT;
    case (f)
      "A": c = CMD_OLDER;
      "B": c = CMD_NEWER;
      "C": c = CMD_RIGHT;
      "D": c = CMD_LEFT;
      "H": c = CMD_HOME;
      "F": c = CMD_END;
      "~": begin
        if (num == 14'd1 || num == 14'd7) c = CMD_HOME;
        else if (num == 14'd4 || num == 14'd8) c = CMD_END;
        else if (num == 14'd3) c = CMD_DELETE;
        else return 1'b0;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit control_key(input logic [7:0] b, output cmd_t c);
    c = CMD_INSERT;
    case (b)
      8'h0D, 8'h0A: c = CMD_ACCEPT;
      8'h04:        c = CMD_CTRL_D;
      8'h01:        c = CMD_HOME;
      8'h05:        c = CMD_END;
      8'h02:        c = CMD_LEFT;
      8'h06:        c = CMD_RIGHT;
      8'h10:        c = CMD_OLDER;
      8'h0E:        c = CMD_NEWER;
      8'h08, KEY_DEL: c = CMD_BACKSPACE;
      8'h0B:        c = CMD_KILL_END;
      8'h15:        c = CMD_KILL_START;
      8'h17:        c = CMD_KILL_WORD;
      default:      return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit escape_step(input logic [7:0] b, output cmd_t c);
    c = CMD_INSERT;
    case (esc_st)
      ESC_SEEN: begin
        if (b == "[") begin
          esc_st = ESC_CSI;
          csi_val = '0;
          csi_frozen = 1'b0;
        end else if (b == "O") begin
          esc_st = ESC_SS3;
        end else begin
          esc_st = ESC_NONE;
        end
        return 1'b0;
      end
      ESC_SS3: begin
        esc_st = ESC_NONE;
        return final_key(b, 14'd0, c);
      end
      default: begin
        if (b >= "0" && b <= "9") begin
          if (!csi_frozen && csi_val < CSI_FREEZE) csi_val = 14'(csi_val * 10 + (b - "0"));
          return 1'b0;
        end
        if (b == ";") begin
          csi_frozen = 1'b1;
          return 1'b0;
        end
        if (b >= 8'h20 && b <= 8'h3F) return 1'b0;
        // anything else ends the sequence; only 0x40..0x7E can name a key
        esc_st = ESC_NONE;
        if (b >= 8'h40 && b <= 8'h7E) return final_key(b, csi_val, c);
        return 1'b0;
      end
    endcase
  endfunction

  function automatic bit decode_key(input logic req, input logic [7:0] b, output key_word_t r);
    logic        tab_before;
    logic [31:0] full;
    logic [2:0]  need;
    cmd_t        c;
    bit          has;
    r.cmd = CMD_INSERT;
    r.bytes = '0;
    r.len = '0;
    r.rep = 1'b0;
    if (req == REQ_TICK) begin
      if (esc_st == ESC_SEEN) esc_st = ESC_NONE;
      return 1'b0;
    end
    tab_before = last_tab;
    last_tab = 1'b0;
    if (esc_st != ESC_NONE) begin
      has = escape_step(b, c);
      r.cmd = c;
      return has;
    end
    if (utf_need != 0) begin
      if (b[7:6] == 2'b10) begin
        full = {8'h00, utf_pend} | ({24'd0, b} << (8 * utf_have));
        if (utf_have + 1 >= utf_need) begin
          r.cmd = CMD_INSERT;
          r.bytes = full;
          r.len = utf_need;
          utf_pend = '0;
          utf_have = '0;
          utf_need = '0;
          return 1'b1;
        end
        utf_pend = full[23:0];
        utf_have = utf_have + 3'd1;
        return 1'b0;
      end
      // interrupted character: drop it and decode this byte afresh
      utf_pend = '0;
      utf_have = '0;
      utf_need = '0;
    end
    if (b == KEY_ESCAPE) begin
      esc_st = ESC_SEEN;
      return 1'b0;
    end
    if (b == KEY_TAB) begin
      last_tab = 1'b1;
      r.cmd = CMD_COMPLETE;
      r.rep = tab_before;
      return 1'b1;
    end
    if (b < 8'h20 || b == KEY_DEL) begin
      has = control_key(b, c);
      r.cmd = c;
      return has;
    end
    if (b < 8'h80) begin
      r.cmd = CMD_INSERT;
      r.bytes = {24'd0, b};
      r.len = 3'd1;
      return 1'b1;
    end
    if (b >= 8'hF0 && b <= 8'hF4) need = 3'd4;
    else if (b >= 8'hE0 && b < 8'hF0) need = 3'd3;
    else if (b >= 8'hC2 && b < 8'hE0) need = 3'd2;
    else need = 3'd0;
    if (need != 0) begin
      utf_pend = {16'd0, b};
      utf_have = 3'd1;
      utf_need = need;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_word(input logic req, input logic [7:0] b);
    int        gap;
    key_word_t r;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    key_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (decode_key(req, b, r)) awaited_keys.push_back(r);
    if (req == REQ_TICK) ticks_sent++;
    else words_sent++;
  endtask

  // hold the sender off until every expected result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_keys.size() != 0);
  endtask

  task automatic test_tab_repeat();
    send_word(REQ_BYTE, KEY_TAB);
    send_word(REQ_BYTE, KEY_TAB);
    send_word(REQ_TICK, 8'hFF);
    send_word(REQ_BYTE, KEY_TAB);
    send_word(REQ_BYTE, "a");
    send_word(REQ_BYTE, KEY_TAB);
  endtask

  task automatic test_controls_and_ascii();
    logic [7:0] seq [8] = '{8'h00, KEY_DEL, 8'h0D, 8'h04, 8'h20, "~", 8'hFF, 8'h80};
    foreach (seq[i]) send_word(REQ_BYTE, seq[i]);
  endtask

  task automatic test_escape_keys();
    // lone ESC dropped by the tick, then an Alt-free 'x'
    send_word(REQ_BYTE, KEY_ESCAPE);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_BYTE, "x");
    send_word(REQ_BYTE, KEY_ESCAPE);
    send_word(REQ_BYTE, "[");
    send_word(REQ_BYTE, "3");
    send_word(REQ_BYTE, "~");
    send_word(REQ_BYTE, KEY_ESCAPE);
    send_word(REQ_BYTE, "O");
    send_word(REQ_BYTE, "A");
  endtask

  task automatic test_utf8();
    logic [7:0] seq [6] = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hC3, "a"};
    foreach (seq[i]) send_word(REQ_BYTE, seq[i]);
  endtask

  task automatic test_random_traffic();
    int         start;
    int         next_break;
    int         kind;
    int         n;
    int         cut;
    int         v;
    int         picks [5] = '{1, 3, 4, 7, 8};
    string      s;
    string      finals = "ABCDHF~~";
    logic [7:0] b;
    start = words_sent;
    next_break = start + 300;
    while (words_sent < start + RANDOM_WORDS) begin
      if (words_sent >= next_break) begin
        drain_results();
        idle_on = ($urandom_range(0, 2) != 0);
        next_break += 300;
      end
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        n = $urandom_range(1, 8);
        repeat (n) send_word(REQ_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
      end else if (kind < 30) begin
        if ($urandom_range(0, 9) < 3) begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            send_word(REQ_BYTE, KEY_TAB);
            if ($urandom_range(0, 5) == 0) send_word(REQ_TICK, 8'($urandom));
          end
        end else begin
          v = $urandom_range(0, 32);
          b = (v == 32) ? KEY_DEL : 8'(v);
          if (b == KEY_ESCAPE) b = KEY_TAB;
          send_word(REQ_BYTE, b);
        end
      end else if (kind < 50) begin
        send_word(REQ_BYTE, KEY_ESCAPE);
        send_word(REQ_BYTE, "[");
        case ($urandom_range(0, 7))
          0, 1, 2, 3, 4: v = picks[$urandom_range(0, 4)];
          5:             v = $urandom_range(0, 99);
          6:             v = $urandom_range(0, 99999);
          default:       v = -1;
        endcase
        if (v >= 0) begin
          s = $sformatf("%0d", v);
          for (int k = 0; k < s.len(); k++) send_word(REQ_BYTE, s[k]);
        end
        if ($urandom_range(0, 3) == 0) begin
          send_word(REQ_BYTE, ";");
          n = $urandom_range(0, 2);
          repeat (n) send_word(REQ_BYTE, 8'($urandom_range("0", "9")));
        end
        if ($urandom_range(0, 9) == 0) send_word(REQ_BYTE, 8'($urandom_range(8'h20, 8'h3F)));
        if ($urandom_range(0, 9) == 0) send_word(REQ_TICK, 8'($urandom));
        v = $urandom_range(0, 9);
        if (v < 6) b = finals[$urandom_range(0, 7)];
        else if (v < 8) b = 8'($urandom_range(8'h40, 8'h7E));
        else if (v == 8) b = ($urandom_range(0, 1) != 0) ? KEY_ESCAPE : 8'($urandom_range(0, 8'h1F));
        else b = 8'($urandom_range(8'h7F, 8'hFF));
        send_word(REQ_BYTE, b);
      end else if (kind < 58) begin
        send_word(REQ_BYTE, KEY_ESCAPE);
        send_word(REQ_BYTE, "O");
        if ($urandom_range(0, 1) != 0) b = finals[$urandom_range(0, 7)];
        else b = 8'($urandom);
        send_word(REQ_BYTE, b);
      end else if (kind < 64) begin
        send_word(REQ_BYTE, KEY_ESCAPE);
        case ($urandom_range(0, 2))
          0:       send_word(REQ_TICK, 8'($urandom));
          1:       send_word(REQ_BYTE, 8'($urandom));
          default: send_word(REQ_BYTE, KEY_ESCAPE);
        endcase
      end else if (kind < 84) begin
        n = $urandom_range(2, 4);
        case (n)
          2:       b = 8'($urandom_range(8'hC2, 8'hDF));
          3:       b = 8'($urandom_range(8'hE0, 8'hEF));
          default: b = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, n - 1) : n;
        send_word(REQ_BYTE, b);
        if ($urandom_range(0, 9) == 0) send_word(REQ_TICK, 8'($urandom));
        for (int k = 1; k < cut; k++) send_word(REQ_BYTE, 8'h80 | 8'($urandom_range(0, 63)));
        if (cut < n) begin
          b = 8'($urandom);
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          send_word(REQ_BYTE, b);
        end
      end else begin
        if ($urandom_range(0, 3) == 0) send_word(REQ_TICK, 8'($urandom));
        else send_word(REQ_BYTE, 8'($urandom));
      end
    end
  endtask

  // result side back-pressure
  always @(posedge clk) begin : ready_gen
    int g;
    if (rd_hold > 0) begin
      rd_hold <= rd_hold - 1;
      out_ready <= 1'b0;
    end else if (!idle_on) begin
      out_ready <= 1'b1;
    end else begin
      g = pick_gap();
      rd_hold <= (g > 0) ? g - 1 : 0;
      out_ready <= (g == 0);
    end
  end

  always @(posedge clk) begin : check_results
    key_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_keys.size() == 0) begin
        report_mismatch($sformatf("unexpected word, command %0d", command));
      end else begin
        want = awaited_keys.pop_front();
        if (command !== want.cmd)
          report_mismatch($sformatf("command %0d, wanted %0d", command, want.cmd));
        if (char_bytes !== want.bytes)
          report_mismatch($sformatf("char_bytes %h, wanted %h", char_bytes, want.bytes));
        if (char_len !== want.len)
          report_mismatch($sformatf("char_len %0d, wanted %0d", char_len, want.len));
        if (tab_repeat !== want.rep)
          report_mismatch($sformatf("tab_repeat %0d, wanted %0d", tab_repeat, want.rep));
        seen_cmd[want.cmd] = 1'b1;
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL terminal_key_decoder_core");
      $finish;
    end
  end

  initial begin : run
    int kinds;
    kinds = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_tab_repeat();
    drain_results();
    test_controls_and_ascii();
    test_escape_keys();
    drain_results();
    idle_on = 1'b0;
    test_utf8();
    drain_results();
    idle_on = 1'b1;
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (awaited_keys.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_keys.size()));
    foreach (seen_cmd[i]) if (seen_cmd[i]) kinds++;
    $display("Sent %0d key bytes and %0d timeout ticks; %0d results checked, %0d of 15 commands",
             words_sent, ticks_sent, results_checked, kinds);
    $display("Covered CSI/SS3 keys, capped parameters, UTF-8 up to four bytes, tab repeats.");
    if (mismatches == 0) begin
      $display("PASS terminal_key_decoder_core");
    end else begin
      $display("FAIL terminal_key_decoder_core");
    end
    $finish;
  end

endmodule
